### rtl/core/pfe_pkg.sv
// Shared constants, codes and helper functions of the paged frame buffer engine.
`default_nettype none
package pfe_pkg;
   localparam int COLUMNS  = 128;
   localparam int PAGES    = 8;
   localparam int SEGMENTS = 16;
   localparam int ROWS     = PAGES * 8;
   localparam int SEG_W    = COLUMNS / SEGMENTS;
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int PG_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int SG_W     = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int ADDR_W   = $clog2(COLUMNS * PAGES);

   localparam logic [2:0] OP_FILL  = 3'd0;
   localparam logic [2:0] OP_BSTART = 3'd1;
   localparam logic [2:0] OP_BBYTE = 3'd2;
   localparam logic [2:0] OP_CLEAR = 3'd3;
   localparam logic [2:0] OP_FLUSH = 3'd4;

   localparam logic [1:0] PAT_WHITE = 2'd0;
   localparam logic [1:0] PAT_BLACK = 2'd1;
   localparam logic [1:0] PAT_GRAY  = 2'd2;

   localparam logic [1:0] REG_GRAY_EVEN = 2'd0;
   localparam logic [1:0] REG_GRAY_ODD  = 2'd1;
   localparam logic [1:0] REG_READY     = 2'd2;

   localparam logic [7:0] CMD_PAGE  = 8'hB0;
   localparam logic [7:0] CMD_COLHI = 8'h10;

   function automatic logic [ADDR_W-1:0] pix_addr(input logic [PG_W-1:0] page,
                                                  input logic [COL_W-1:0] col);
      pix_addr = ADDR_W'(ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(col));
   endfunction

   function automatic logic [SG_W-1:0] seg_of(input logic [COL_W-1:0] col);
      logic [COL_W:0] s;
      s = (COL_W+1)'(col / SEG_W);
      if (s >= (COL_W+1)'(SEGMENTS))
         seg_of = SG_W'(SEGMENTS - 1);
      else
         seg_of = s[SG_W-1:0];
   endfunction

   function automatic logic [7:0] mask_for(input logic is_top, input logic is_bot,
                                           input logic [2:0] off, input logic [8:0] brow);
      logic [7:0] m;
      m = 8'hFF;
      if (is_top)
         m = m << off;
      if (is_bot && (brow < 9'(ROWS)))
         m = m & (8'hFF >> (3'd7 - brow[2:0]));
      mask_for = m;
   endfunction
endpackage
`default_nettype wire

### rtl/core/pfe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module pfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we)
         mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### rtl/core/paged_framebuffer_engine_core.sv
// Paged frame buffer engine: pixel store, blit, fill, clear and dirty-segment flush.
// Fill reads and rewrites each painted column byte in turn, a blit byte is read and then
// rewritten, clear writes every location, and flush sends any command words it needs
// and then reads and sends its data words, holding each word while rsp_stall is high.
// One item is worked on at a time. Reset: synchronous; a clearing pass zeroes the pixel
// memory, during which no item is accepted.
`default_nettype none
module paged_framebuffer_engine_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_operation,
   input  wire logic [7:0] req_x_pos,
   input  wire logic [7:0] req_y_pos,
   input  wire logic [7:0] req_rect_width,
   input  wire logic [7:0] req_rect_height,
   input  wire logic [1:0] req_fill_pattern,
   input  wire logic       req_invert,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_data,
   output logic            rsp_last_of_run,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);
   import pfe_pkg::*;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_FRD, S_FWR, S_BRD, S_BWR, S_CMD, S_DRD, S_DOUT, S_SEND, S_FDONE
   } state_type;

   state_type state_ff, ret_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [PAGES-1:0][SEGMENTS-1:0] dirty_ff;
   logic [7:0] gray_even_ff, gray_odd_ff;
   logic       ready_ff;

   logic [COL_W-1:0] f_left_ff, f_right_ff, f_col_ff;
   logic [PG_W-1:0]  f_top_ff, f_bot_ff, f_page_ff;
   logic [2:0]       f_off_ff;
   logic [8:0]       f_brow_ff;
   logic [1:0]       f_pat_ff;

   logic             b_on_ff, b_inv_ff;
   logic [COL_W-1:0] b_left_ff, b_right_ff, b_col_ff;
   logic [PG_W-1:0]  b_top_ff, b_bot_ff, b_page_ff;
   logic [2:0]       b_off_ff;
   logic [8:0]       b_brow_ff;
   logic [7:0]       b_data_ff;

   logic             pos_valid_ff;
   logic [PG_W-1:0]  pos_page_ff;
   logic [COL_W:0]   pos_col_ff;
   logic [PG_W-1:0]  fl_page_ff;
   logic [SG_W-1:0]  fl_seg_ff;
   logic [COL_W-1:0] fl_col_ff, fl_last_ff;
   logic [COL_W:0]   fl_end_ff;
   logic             need_page_ff, need_colh_ff, need_coll_ff;

   logic [7:0] rsp_byte_ff;
   logic       rsp_valid_ff, rsp_data_ff, rsp_last_ff;

   logic              pix_we, spill_we;
   logic [ADDR_W-1:0] pix_waddr, pix_raddr;
   logic [7:0]        pix_wdata, pix_rdata, spill_wdata, spill_rdata;

   logic [8:0] w_right, w_brow;
   logic [5:0] w_botraw;
   logic       w_ok;
   logic [COL_W-1:0] w_rclip;
   logic [PG_W-1:0]  w_bclip, w_top;

   logic [PG_W-1:0] pick_page;
   logic [SG_W-1:0] pick_seg;
   logic            any_dirty;
   logic [SEGMENTS-1:0] pick_row;
   logic [COL_W:0]  pick_first, pick_end;

   logic [7:0]  f_mask, f_val, b_mask, b_v, b_val;
   logic [15:0] b_sh;

   logic accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_is_data     = rsp_data_ff;
   assign rsp_last_of_run = rsp_last_ff;

   always_comb begin
      w_brow   = 9'(req_y_pos) + 9'(req_rect_height) - 9'd1;
      w_right  = 9'(req_x_pos) + 9'(req_rect_width) - 9'd1;
      w_ok     = (9'(req_x_pos) < 9'(COLUMNS)) && (9'(req_y_pos) < 9'(ROWS)) &&
                 (req_rect_width != 8'd0) && (req_rect_height != 8'd0);
      w_rclip  = (w_right >= 9'(COLUMNS)) ? COL_W'(COLUMNS - 1) : w_right[COL_W-1:0];
      w_botraw = w_brow[8:3];
      w_bclip  = (w_botraw >= 6'(PAGES)) ? PG_W'(PAGES - 1) : w_botraw[PG_W-1:0];
      w_top    = PG_W'(req_y_pos[7:3]);
   end

   always_comb begin
      pick_page = '0;
      any_dirty = 1'b0;
      for (int i = PAGES - 1; i >= 0; i--) begin
         if (dirty_ff[i] != '0) begin
            pick_page = PG_W'(i);
            any_dirty = 1'b1;
         end
      end
      pick_row = dirty_ff[pick_page];
      pick_seg = '0;
      for (int j = SEGMENTS - 1; j >= 0; j--) begin
         if (pick_row[j])
            pick_seg = SG_W'(j);
      end
      pick_first = (COL_W+1)'((COL_W+1)'(pick_seg) * (COL_W+1)'(SEG_W));
      pick_end   = (pick_seg == SG_W'(SEGMENTS - 1)) ? (COL_W+1)'(COLUMNS)
                                                     : pick_first + (COL_W+1)'(SEG_W);
   end

   always_comb begin
      f_mask = mask_for(f_page_ff == f_top_ff, f_page_ff == f_bot_ff, f_off_ff, f_brow_ff);
      case (f_pat_ff)
         PAT_WHITE: f_val = 8'h00;
         PAT_BLACK: f_val = 8'hFF;
         PAT_GRAY:  f_val = f_col_ff[0] ? gray_odd_ff : gray_even_ff;
         default:   f_val = 8'h00;
      endcase
      b_v    = b_inv_ff ? ~b_data_ff : b_data_ff;
      b_sh   = {8'h00, b_v} << b_off_ff;
      b_val  = b_sh[7:0] | ((b_page_ff == b_top_ff) ? 8'h00 : spill_rdata);
      b_mask = mask_for(b_page_ff == b_top_ff, b_page_ff == b_bot_ff, b_off_ff, b_brow_ff);
   end

   always_comb begin
      pix_we      = 1'b0;
      pix_waddr   = clr_cnt_ff;
      pix_wdata   = 8'h00;
      pix_raddr   = pix_addr(fl_page_ff, fl_col_ff);
      spill_we    = 1'b0;
      spill_wdata = b_sh[15:8];
      case (state_ff)
         S_CLR: begin
            pix_we = 1'b1;
         end
         S_FRD: begin
            pix_raddr = pix_addr(f_page_ff, f_col_ff);
         end
         S_FWR: begin
            pix_we    = 1'b1;
            pix_waddr = pix_addr(f_page_ff, f_col_ff);
            pix_wdata = (pix_rdata & ~f_mask) | (f_val & f_mask);
         end
         S_BRD: begin
            pix_raddr = pix_addr(b_page_ff, b_col_ff);
         end
         S_BWR: begin
            pix_we    = 1'b1;
            spill_we  = 1'b1;
            pix_waddr = pix_addr(b_page_ff, b_col_ff);
            pix_wdata = (pix_rdata & ~b_mask) | (b_val & b_mask);
         end
         default: begin
            pix_we = 1'b0;
         end
      endcase
   end

   pfe_ram #(.WIDTH(8), .DEPTH(COLUMNS * PAGES)) u_pixel_ram (
      .clock (clock),
      .we    (pix_we),
      .waddr (pix_waddr),
      .wdata (pix_wdata),
      .raddr (pix_raddr),
      .rdata (pix_rdata)
   );

   pfe_ram #(.WIDTH(8), .DEPTH(COLUMNS)) u_spill_ram (
      .clock (clock),
      .we    (spill_we),
      .waddr (b_col_ff),
      .wdata (spill_wdata),
      .raddr (b_col_ff),
      .rdata (spill_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         ret_ff       <= S_IDLE;
         clr_cnt_ff   <= '0;
         dirty_ff     <= '0;
         gray_even_ff <= 8'hAA;
         gray_odd_ff  <= 8'h55;
         ready_ff     <= 1'b0;
         b_on_ff      <= 1'b0;
         pos_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         need_page_ff <= 1'b0;
         need_colh_ff <= 1'b0;
         need_coll_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GRAY_EVEN: gray_even_ff <= csr_wdata;
               REG_GRAY_ODD:  gray_odd_ff  <= csr_wdata;
               REG_READY:     ready_ff     <= csr_wdata[0];
               default:       ;
            endcase
         end
         case (state_ff)
            S_CLR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == ADDR_W'(COLUMNS * PAGES - 1))
                  state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (accept) begin
                  case (req_operation)
                     OP_FILL: begin
                        f_left_ff  <= req_x_pos[COL_W-1:0];
                        f_col_ff   <= req_x_pos[COL_W-1:0];
                        f_right_ff <= w_rclip;
                        f_top_ff   <= w_top;
                        f_page_ff  <= w_top;
                        f_bot_ff   <= w_bclip;
                        f_off_ff   <= req_y_pos[2:0];
                        f_brow_ff  <= w_brow;
                        f_pat_ff   <= req_fill_pattern;
                        if (w_ok && req_fill_pattern <= PAT_GRAY)
                           state_ff <= S_FRD;
                     end
                     OP_BSTART: begin
                        b_on_ff    <= w_ok;
                        b_left_ff  <= req_x_pos[COL_W-1:0];
                        b_col_ff   <= req_x_pos[COL_W-1:0];
                        b_right_ff <= w_rclip;
                        b_top_ff   <= w_top;
                        b_page_ff  <= w_top;
                        b_bot_ff   <= w_bclip;
                        b_off_ff   <= req_y_pos[2:0];
                        b_brow_ff  <= w_brow;
                        b_inv_ff   <= req_invert;
                     end
                     OP_BBYTE: begin
                        b_data_ff <= req_data_byte;
                        if (b_on_ff)
                           state_ff <= S_BRD;
                     end
                     OP_CLEAR: begin
                        dirty_ff   <= '1;
                        clr_cnt_ff <= '0;
                        state_ff   <= S_CLR;
                     end
                     OP_FLUSH: begin
                        fl_page_ff   <= pick_page;
                        fl_seg_ff    <= pick_seg;
                        fl_col_ff    <= pick_first[COL_W-1:0];
                        fl_end_ff    <= pick_end;
                        fl_last_ff   <= COL_W'(pick_end - 1'b1);
                        need_page_ff <= !pos_valid_ff || pos_page_ff != pick_page;
                        need_colh_ff <= !pos_valid_ff || pos_page_ff != pick_page ||
                                        pos_col_ff != pick_first;
                        need_coll_ff <= !pos_valid_ff || pos_page_ff != pick_page ||
                                        pos_col_ff != pick_first;
                        if (ready_ff && any_dirty)
                           state_ff <= S_CMD;
                     end
                     default: ;
                  endcase
               end
            end
            S_FRD: state_ff <= S_FWR;
            S_FWR: begin
               dirty_ff[f_page_ff][seg_of(f_col_ff)] <= 1'b1;
               state_ff <= S_FRD;
               if (f_col_ff == f_right_ff) begin
                  f_col_ff <= f_left_ff;
                  if (f_page_ff == f_bot_ff)
                     state_ff <= S_IDLE;
                  else
                     f_page_ff <= f_page_ff + 1'b1;
               end else begin
                  f_col_ff <= f_col_ff + 1'b1;
               end
            end
            S_BRD: state_ff <= S_BWR;
            S_BWR: begin
               dirty_ff[b_page_ff][seg_of(b_col_ff)] <= 1'b1;
               state_ff <= S_IDLE;
               if (b_col_ff == b_right_ff) begin
                  b_col_ff <= b_left_ff;
                  if (b_page_ff == b_bot_ff)
                     b_on_ff <= 1'b0;
                  else
                     b_page_ff <= b_page_ff + 1'b1;
               end else begin
                  b_col_ff <= b_col_ff + 1'b1;
               end
            end
            S_CMD: begin
               rsp_data_ff <= 1'b0;
               rsp_last_ff <= 1'b0;
               ret_ff      <= S_CMD;
               if (need_page_ff) begin
                  rsp_byte_ff  <= CMD_PAGE | 8'(fl_page_ff);
                  need_page_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_SEND;
               end else if (need_colh_ff) begin
                  rsp_byte_ff  <= CMD_COLHI | 8'({fl_col_ff} >> 4);
                  need_colh_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_SEND;
               end else if (need_coll_ff) begin
                  rsp_byte_ff  <= {4'h0, 4'(fl_col_ff)};
                  need_coll_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_SEND;
               end else begin
                  state_ff <= S_DRD;
               end
            end
            S_DRD: state_ff <= S_DOUT;
            S_DOUT: begin
               rsp_byte_ff  <= ~pix_rdata;
               rsp_data_ff  <= 1'b1;
               rsp_last_ff  <= (fl_col_ff == fl_last_ff);
               rsp_valid_ff <= 1'b1;
               ret_ff       <= (fl_col_ff == fl_last_ff) ? S_FDONE : S_DRD;
               fl_col_ff    <= fl_col_ff + 1'b1;
               state_ff     <= S_SEND;
            end
            S_SEND: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ret_ff;
               end
            end
            S_FDONE: begin
               dirty_ff[fl_page_ff][fl_seg_ff] <= 1'b0;
               pos_page_ff <= fl_page_ff;
               pos_col_ff  <= fl_end_ff;
               pos_valid_ff <= (dirty_ff[fl_page_ff] &
                               ~(SEGMENTS'(1) << fl_seg_ff)) != '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_no_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("result word pending while accepting items");

   a_rsp_needs_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ready_ff)
      else $error("flush word emitted while panel not ready");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |-> rsp_is_data)
      else $error("run closed on a command word");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLR |-> !rsp_valid && pix_we)
      else $error("clearing pass not writing");
endmodule
`default_nettype wire

### tb/tb_paged_framebuffer_engine_core.sv
// Self-checking testbench of the paged frame buffer engine: directed and random fill, blit, clear and flush.
`default_nettype none
module tb_paged_framebuffer_engine_core;
   import pfe_pkg::*;

   typedef struct {
      logic [2:0] operation;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic [7:0] rect_width;
      logic [7:0] rect_height;
      logic [1:0] fill_pattern;
      logic       invert;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last_of_run;
   } panel_word_type;

   class panel_scoreboard;
      logic [7:0]  pixels [COLUMNS*PAGES];
      logic [15:0] dirty [PAGES];
      logic [7:0]  carry [COLUMNS];
      logic [7:0]  gray_even, gray_odd;
      bit          ready;
      bit          blit_on, b_inv;
      int          b_left, b_right, b_top, b_bottom, b_off, b_brow;
      int          cur_col, cur_page;
      bit          pos_ok;
      int          pos_page, pos_col;
      panel_word_type panel_q[$];
      int          errors, words_checked, flushes_sent;

      function new();
         foreach (pixels[i]) pixels[i] = 8'h00;
         foreach (dirty[i]) dirty[i] = '0;
         foreach (carry[i]) carry[i] = 8'h00;
         gray_even = 8'hAA;
         gray_odd  = 8'h55;
      endfunction

      function void set_reg(logic [1:0] idx, logic [7:0] val);
         if (idx == REG_GRAY_EVEN) gray_even = val;
         else if (idx == REG_GRAY_ODD) gray_odd = val;
         else if (idx == REG_READY) ready = val[0];
      endfunction

      function bit clip(int x, int y, int w, int h, output int right, output int bottom,
                        output int brow);
         right = 0;
         bottom = 0;
         brow = 0;
         if (x >= COLUMNS || y >= ROWS || w == 0 || h == 0) return 0;
         brow = y + h - 1;
         right = (x + w - 1 >= COLUMNS) ? COLUMNS - 1 : x + w - 1;
         bottom = (brow / 8 >= PAGES) ? PAGES - 1 : brow / 8;
         return 1;
      endfunction

      function logic [7:0] row_mask(int page, int top, int bottom, int off, int brow);
         logic [7:0] m;
         m = 8'hFF;
         if (page == top) m = m << off;
         if (page == bottom && brow < ROWS) m = m & (8'hFF >> (7 - brow % 8));
         return m;
      endfunction

      function void paint(int page, int col, logic [7:0] m, logic [7:0] v);
         int idx, s;
         idx = page * COLUMNS + col;
         s = col / SEG_W;
         if (s >= SEGMENTS) s = SEGMENTS - 1;
         pixels[idx] = (pixels[idx] & ~m) | (v & m);
         dirty[page][s] = 1'b1;
      endfunction

      function void fill_rect(req_word_type r);
         int right, bottom, brow, top;
         logic [7:0] v;
         if (r.fill_pattern > PAT_GRAY) return;
         if (!clip(r.x_pos, r.y_pos, r.rect_width, r.rect_height, right, bottom, brow)) return;
         top = r.y_pos / 8;
         for (int p = top; p <= bottom; p++)
            for (int c = r.x_pos; c <= right; c++) begin
               if (r.fill_pattern == PAT_WHITE) v = 8'h00;
               else if (r.fill_pattern == PAT_BLACK) v = 8'hFF;
               else v = c[0] ? gray_odd : gray_even;
               paint(p, c, row_mask(p, top, bottom, r.y_pos % 8, brow), v);
            end
      endfunction

      function void blit_word(logic [7:0] d);
         logic [7:0] v, val;
         if (!blit_on) return;
         v = b_inv ? ~d : d;
         val = v << b_off;
         if (cur_page == b_top) carry[cur_col] = 8'h00;
         else val = val | carry[cur_col];
         if (b_off > 0) carry[cur_col] = v >> (8 - b_off);
         paint(cur_page, cur_col, row_mask(cur_page, b_top, b_bottom, b_off, b_brow), val);
         cur_col++;
         if (cur_col > b_right) begin
            cur_col = b_left;
            cur_page++;
            if (cur_page > b_bottom) blit_on = 0;
         end
      endfunction

      function void flush_step();
         int page, seg, first, stop;
         panel_word_type w, run[$];
         if (!ready) return;
         page = 0;
         while (page < PAGES && dirty[page] == 0) page++;
         if (page >= PAGES) return;
         seg = 0;
         while (!dirty[page][seg]) seg++;
         first = seg * SEG_W;
         stop = (seg == SEGMENTS - 1) ? COLUMNS : first + SEG_W;
         w.is_data = 0;
         w.last_of_run = 0;
         if (!pos_ok || pos_page != page) begin
            w.out_byte = CMD_PAGE | 8'(page & 15);
            run.push_back(w);
            pos_ok = 0;
         end
         if (!pos_ok || pos_col != first) begin
            w.out_byte = CMD_COLHI | 8'(first >> 4);
            run.push_back(w);
            w.out_byte = 8'(first & 15);
            run.push_back(w);
         end
         w.is_data = 1;
         for (int c = first; c < stop; c++) begin
            w.out_byte = ~pixels[page * COLUMNS + c];
            run.push_back(w);
         end
         run[run.size() - 1].last_of_run = 1;
         foreach (run[i]) panel_q.push_back(run[i]);
         flushes_sent++;
         dirty[page][seg] = 1'b0;
         pos_ok = (dirty[page] != 0);
         pos_page = page;
         pos_col = stop;
      endfunction

      function void note_word(req_word_type r);
         case (r.operation)
            OP_FILL: fill_rect(r);
            OP_BSTART: begin
               blit_on = clip(r.x_pos, r.y_pos, r.rect_width, r.rect_height,
                              b_right, b_bottom, b_brow);
               b_left = r.x_pos;
               b_top = r.y_pos / 8;
               b_off = r.y_pos % 8;
               b_inv = r.invert;
               cur_col = blit_on ? r.x_pos : 0;
               cur_page = blit_on ? r.y_pos / 8 : 0;
            end
            OP_BBYTE: blit_word(r.data_byte);
            OP_CLEAR: begin
               foreach (pixels[i]) pixels[i] = 8'h00;
               foreach (dirty[i]) dirty[i] = 16'((1 << SEGMENTS) - 1);
            end
            OP_FLUSH: flush_step();
            default: ;
         endcase
      endfunction

      function void check_word(logic [7:0] out_byte, logic is_data, logic last_of_run);
         panel_word_type e;
         words_checked++;
         if (panel_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected word out_byte=%h is_data=%b last_of_run=%b",
                     $time, out_byte, is_data, last_of_run);
            return;
         end
         e = panel_q.pop_front();
         if (out_byte !== e.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, out_byte);
         end
         if (is_data !== e.is_data) begin
            errors++;
            $display("%0t: is_data expected %b actual %b", $time, e.is_data, is_data);
         end
         if (last_of_run !== e.last_of_run) begin
            errors++;
            $display("%0t: last_of_run expected %b actual %b", $time, e.last_of_run,
                     last_of_run);
         end
      endfunction
   endclass

   logic       clock, reset;
   logic       req_valid, req_stall;
   logic [2:0] req_operation;
   logic [7:0] req_x_pos, req_y_pos, req_rect_width, req_rect_height, req_data_byte;
   logic [1:0] req_fill_pattern;
   logic       req_invert;
   logic       rsp_valid, rsp_stall, rsp_is_data, rsp_last_of_run;
   logic [7:0] rsp_out_byte;
   logic       csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   panel_scoreboard sb = new();
   int items_sent, burst_left, stall_mode, stall_count;

   paged_framebuffer_engine_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_x_pos(req_x_pos), .req_y_pos(req_y_pos), .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height), .req_fill_pattern(req_fill_pattern),
      .req_invert(req_invert), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_byte(rsp_out_byte),
      .rsp_is_data(rsp_is_data), .rsp_last_of_run(rsp_last_of_run),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("tb_paged_framebuffer_engine_core failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_out_byte, rsp_is_data, rsp_last_of_run);
      if (stall_count == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_count <= $urandom_range(50, 300);
      end else begin
         stall_count <= stall_count - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   function automatic req_word_type rand_word(logic [2:0] op);
      req_word_type r;
      r.operation = op;
      r.x_pos = 8'($urandom);
      r.y_pos = 8'($urandom);
      r.rect_width = 8'($urandom);
      r.rect_height = 8'($urandom);
      r.fill_pattern = 2'($urandom);
      r.invert = 1'($urandom);
      r.data_byte = 8'($urandom);
      return r;
   endfunction

   task automatic send(req_word_type r);
      req_valid <= 1'b1;
      req_operation <= r.operation;
      req_x_pos <= r.x_pos;
      req_y_pos <= r.y_pos;
      req_rect_width <= r.rect_width;
      req_rect_height <= r.rect_height;
      req_fill_pattern <= r.fill_pattern;
      req_invert <= r.invert;
      req_data_byte <= r.data_byte;
      do @(posedge clock); while (req_stall);
      sb.note_word(r);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic send_rect(logic [2:0] op, int x, int y, int w, int h, int pat, int inv);
      req_word_type r;
      r = rand_word(op);
      r.x_pos = 8'(x);
      r.y_pos = 8'(y);
      r.rect_width = 8'(w);
      r.rect_height = 8'(h);
      r.fill_pattern = 2'(pat);
      r.invert = 1'(inv);
      send(r);
   endtask

   task automatic send_byte(logic [7:0] d);
      req_word_type r;
      r = rand_word(OP_BBYTE);
      r.data_byte = d;
      send(r);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
   endtask

   task automatic csr_idle();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.panel_q.size() != 0) @(posedge clock);
      repeat (2600) @(posedge clock);
   endtask

   task automatic random_phase(int target);
      int pick, n, right, bottom, brow, x, y, w, h;
      req_word_type r;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            x = $urandom_range(0, COLUMNS - 1);
            y = $urandom_range(0, ROWS - 1);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 20);
            void'(sb.clip(x, y, w, h, right, bottom, brow));
            n = (right - x + 1) * (bottom - y / 8 + 1);
            if (n > 60) w = 1;
            void'(sb.clip(x, y, w, h, right, bottom, brow));
            n = (right - x + 1) * (bottom - y / 8 + 1);
            send_rect(OP_BSTART, x, y, w, h, $urandom_range(0, 3), $urandom_range(0, 1));
            for (int i = 0; i < n; i++) begin
               send_byte(8'($urandom));
               if ($urandom_range(0, 15) == 0) send(rand_word(OP_FLUSH));
            end
         end else if (pick < 45) begin
            send(rand_word(OP_BSTART));
            repeat ($urandom_range(0, 6)) send_byte(8'($urandom));
         end else if (pick < 60) begin
            r = rand_word(OP_FILL);
            if ($urandom_range(0, 9) != 0) begin
               r.x_pos = 8'($urandom_range(0, 140));
               r.rect_width = 8'($urandom_range(0, 16));
            end
            send(r);
         end else if (pick < 63) begin
            send(rand_word(OP_CLEAR));
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 4)) send(rand_word(OP_FLUSH));
         end else if (pick < 94) begin
            send(rand_word(3'($urandom_range(5, 7))));
         end else begin
            send(rand_word(OP_BBYTE));
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_FILL;
      req_x_pos <= '0;
      req_y_pos <= '0;
      req_rect_width <= '0;
      req_rect_height <= '0;
      req_fill_pattern <= PAT_WHITE;
      req_invert <= 1'b0;
      req_data_byte <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= REG_GRAY_EVEN;
      csr_wdata <= '0;
      stall_mode = 0;
      stall_count = 0;
      burst_left = 5;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      csr_write(REG_GRAY_EVEN, 8'h00);
      csr_write(REG_GRAY_ODD, 8'hFF);
      csr_write(REG_READY, 8'h01);
      csr_idle();

      send_rect(OP_FILL, 0, 0, 255, 255, PAT_BLACK, 0);
      send(rand_word(OP_FLUSH));
      send(rand_word(OP_FLUSH));
      send_rect(OP_FILL, 120, 60, 255, 255, PAT_GRAY, 1);
      send_rect(OP_FILL, 3, 3, 10, 10, 3, 0);
      send_rect(OP_FILL, 128, 0, 4, 4, PAT_BLACK, 0);
      send_rect(OP_FILL, 0, 0, 0, 8, PAT_BLACK, 0);
      send_rect(OP_FILL, 0, 64, 8, 8, PAT_BLACK, 0);
      send_rect(OP_FILL, 0, 0, 8, 0, PAT_BLACK, 0);
      send_rect(OP_FILL, 9, 5, 3, 1, PAT_WHITE, 0);
      send(rand_word(OP_CLEAR));
      send(rand_word(OP_FLUSH));
      send_rect(OP_BSTART, 5, 3, 2, 10, PAT_WHITE, 1);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h81);
      send_byte(8'h7E);
      send_byte(8'h5A);
      send_rect(OP_BSTART, 200, 0, 4, 4, PAT_WHITE, 0);
      send_byte(8'hFF);
      send(rand_word(3'd7));
      repeat (3) send(rand_word(OP_FLUSH));
      random_phase(140);
      settle();

      csr_write(REG_READY, 8'h00);
      csr_write(REG_GRAY_EVEN, 8'hFF);
      csr_write(REG_GRAY_ODD, 8'h00);
      csr_idle();
      random_phase(220);
      settle();

      csr_write(REG_GRAY_EVEN, 8'($urandom));
      csr_write(REG_GRAY_ODD, 8'($urandom));
      csr_write(REG_READY, 8'h01);
      csr_idle();
      random_phase(380);
      settle();

      if (sb.panel_q.size() != 0) sb.errors++;
      $display("Sent %0d request words over three register settings.", items_sent);
      $display("Checked %0d panel words from %0d flush steps, %0d errors.",
               sb.words_checked, sb.flushes_sent, sb.errors);
      if (sb.errors == 0)
         $display("tb_paged_framebuffer_engine_core passed");
      else
         $display("tb_paged_framebuffer_engine_core failed");
      $finish;
   end
endmodule
`default_nettype wire

### files.f
rtl/core/pfe_pkg.sv
rtl/core/pfe_ram.sv
rtl/core/paged_framebuffer_engine_core.sv
tb/tb_paged_framebuffer_engine_core.sv
